// ----- sv/ssba_pkg.sv -----
package ssba_pkg;

   localparam int OP_W = 2;
   localparam int BASE_W = 17;
   localparam int IDX_W = 12;
   localparam int SHIFT_W = 14;
   localparam int CFG_W = 13;
   localparam int CSR_IDX_W = 2;
   localparam int BIN_CALC_W = 20;
   localparam int MAG_CMP_W = 18;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd1;
   localparam logic [OP_W-1:0] OP_SHIFT = 2'd2;
   localparam logic [OP_W-1:0] OP_READ = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TRANSFORM_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_BINS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BINS = 2'd2;

   localparam logic [CFG_W-1:0] TRANSFORM_LENGTH_RESET = 13'd1024;
   localparam logic [CFG_W-1:0] BAND_BINS_RESET = 13'd256;
   localparam logic [CFG_W-1:0] WINDOW_BINS_RESET = 13'd4096;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_SHIFT,
      ST_RD_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// ----- sv/ssba_req_if.sv -----
interface ssba_req_if #(parameter int SAMPLE_WIDTH = 24) ();
   import ssba_pkg::*;
   logic valid;
   logic ready;
   logic [OP_W-1:0] opcode;
   logic signed [BASE_W-1:0] base_bin;
   logic [IDX_W-1:0] sample_index;
   logic signed [SAMPLE_WIDTH-1:0] sample_re;
   logic signed [SAMPLE_WIDTH-1:0] sample_im;
   logic signed [SHIFT_W-1:0] shift_bins;

   modport source (output valid, opcode, base_bin, sample_index, sample_re, sample_im,
                   shift_bins, input ready);
   modport sink (input valid, opcode, base_bin, sample_index, sample_re, sample_im,
                 shift_bins, output ready);
endinterface

// ----- sv/ssba_rsp_if.sv -----
interface ssba_rsp_if #(parameter int SAMPLE_WIDTH = 24, parameter int COUNT_WIDTH = 16) ();
   logic valid;
   logic ready;
   logic signed [SAMPLE_WIDTH-1:0] avg_re;
   logic signed [SAMPLE_WIDTH-1:0] avg_im;
   logic [COUNT_WIDTH-1:0] bin_count;

   modport source (output valid, avg_re, avg_im, bin_count, input ready);
   modport sink (input valid, avg_re, avg_im, bin_count, output ready);
endinterface

// ----- sv/swept_spectrum_bin_accumulator_core.sv -----
// Accumulate words are taken one per cycle while the core is idle; the
// read-modify-write of a bin registers the memory read and the sample, then
// writes the sum back, and forwards the last write when the same bin is hit again.
// A read word is averaged by a bit-serial divider. A shift moves, and a clear
// zeroes, one memory entry a cycle. After reset, which is synchronous and active
// high, a clearing pass zeroes the memory; no word is accepted until it is done.
module swept_spectrum_bin_accumulator_core #(
   parameter int BIN_DEPTH = 4096,
   parameter int SAMPLE_WIDTH = 24,
   parameter int COUNT_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   ssba_req_if.sink req_ch,
   ssba_rsp_if.source rsp_ch,
   input  logic csr_we,
   input  logic [ssba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ssba_pkg::CFG_W-1:0] csr_wdata
);
   import ssba_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int CW = COUNT_WIDTH;
   localparam int AW = $clog2(BIN_DEPTH);
   localparam int NW = AW + 1;
   localparam int ACC_W = SW + CW;
   localparam int WW = 2 * ACC_W + CW;
   localparam int STEP_W = $clog2(ACC_W + 1);
   localparam int EXT_W = CFG_W + NW;

   logic [CFG_W-1:0] len_ff, bw_ff, winreg_ff;
   logic [NW-1:0] win, newwin;

   state_type state_ff, state_in;
   logic [NW-1:0] ptr_ff, ptr_in, end_ff, end_in;
   logic [NW-1:0] mv_src_ff, mv_src_in, mv_dst_ff, mv_dst_in, mv_left_ff, mv_left_in;
   logic mv_down_ff, mv_down_in, pend_ff, pend_in;
   logic [NW-1:0] pend_dst_ff, pend_dst_in;
   logic rd_ok_ff, rd_ok_in;
   logic [ACC_W-1:0] dq_re_ff, dq_re_in, dq_im_ff, dq_im_in;
   logic [CW-1:0] rem_re_ff, rem_re_in, rem_im_ff, rem_im_in;
   logic [CW-1:0] divisor_ff, divisor_in;
   logic neg_re_ff, neg_re_in, neg_im_ff, neg_im_in, zero_res_ff, zero_res_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic [SW-1:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic [CW-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic s1_vld_ff, s1_vld_in;
   logic [SW-1:0] s1_re_ff, s1_im_ff;

   logic [WW-1:0] mem [BIN_DEPTH];
   logic [WW-1:0] rdata_ff, fwd_data_ff, wdata, mem_q, acc_new;
   logic [AW-1:0] raddr, raddr_ff, waddr, fwd_addr_ff;
   logic we, fwd_vld_ff;

   logic [CFG_W-1:0] lo, hi, half_sum, idx_ext;
   logic [CFG_W:0] len_bw_sum;
   logic [BIN_CALC_W-1:0] bin_calc, ridx_calc;
   logic in_band, in_win, acc_take, req_acc;
   logic [SHIFT_W-1:0] shift_mag;
   logic [MAG_CMP_W-1:0] mag_ext, win_ext;
   logic [NW-1:0] shift_n;
   logic [ACC_W-1:0] q_re, q_im;
   logic [CW-1:0] q_cnt;
   logic [CW:0] rt_re, rt_im;
   logic ge_re, ge_im;
   logic [SW-1:0] quo_re, quo_im;
   logic s1_wr;

   always_comb begin
      if (EXT_W'(winreg_ff) < EXT_W'(BIN_DEPTH)) begin
         win = NW'(winreg_ff);
      end else begin
         win = NW'(BIN_DEPTH);
      end
      if (EXT_W'(csr_wdata) < EXT_W'(BIN_DEPTH)) begin
         newwin = NW'(csr_wdata);
      end else begin
         newwin = NW'(BIN_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= TRANSFORM_LENGTH_RESET;
         bw_ff <= BAND_BINS_RESET;
         winreg_ff <= WINDOW_BINS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRANSFORM_LENGTH: len_ff <= csr_wdata;
            CSR_BAND_BINS: bw_ff <= csr_wdata;
            CSR_WINDOW_BINS: winreg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Band limits and target bin of an accumulate word.
   always_comb begin
      idx_ext = CFG_W'(req_ch.sample_index);
      lo = (len_ff >= bw_ff) ? CFG_W'((len_ff - bw_ff) >> 1) : '0;
      len_bw_sum = {1'b0, len_ff} + {1'b0, bw_ff};
      half_sum = len_bw_sum[CFG_W:1];
      hi = (half_sum > len_ff) ? len_ff : half_sum;
      in_band = (idx_ext >= lo) && (idx_ext < hi);
      bin_calc = {{(BIN_CALC_W-BASE_W){req_ch.base_bin[BASE_W-1]}}, req_ch.base_bin}
                 + BIN_CALC_W'(req_ch.sample_index) - BIN_CALC_W'(len_ff >> 1);
      in_win = !bin_calc[BIN_CALC_W-1] && (bin_calc < BIN_CALC_W'(win));
      acc_take = in_band && in_win;
      ridx_calc = BIN_CALC_W'(req_ch.sample_index);
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc = req_ch.valid && req_ch.ready;

   always_comb begin
      if (state_ff == ST_SHIFT) begin
         raddr = mv_src_ff[AW-1:0];
      end else if (req_ch.opcode == OP_ACCUMULATE) begin
         raddr = bin_calc[AW-1:0];
      end else begin
         raddr = ridx_calc[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign mem_q = (fwd_vld_ff && (fwd_addr_ff == raddr_ff)) ? fwd_data_ff : rdata_ff;
   assign q_re = mem_q[WW-1 -: ACC_W];
   assign q_im = mem_q[CW +: ACC_W];
   assign q_cnt = mem_q[CW-1:0];

   assign acc_new = {q_re + {{CW{s1_re_ff[SW-1]}}, s1_re_ff},
                     q_im + {{CW{s1_im_ff[SW-1]}}, s1_im_ff},
                     q_cnt + CW'(1)};
   assign s1_wr = s1_vld_ff && (q_cnt != {CW{1'b1}});
   assign s1_vld_in = req_acc && (req_ch.opcode == OP_ACCUMULATE) && acc_take;

   always_comb begin
      we = 1'b0;
      waddr = raddr_ff;
      wdata = acc_new;
      if (s1_wr) begin
         we = 1'b1;
      end else if (state_ff == ST_SHIFT && pend_ff) begin
         we = 1'b1;
         waddr = pend_dst_ff[AW-1:0];
         wdata = mem_q;
      end else if (state_ff == ST_SWEEP && ptr_ff < end_ff) begin
         we = 1'b1;
         waddr = ptr_ff[AW-1:0];
         wdata = '0;
      end
   end

   always_comb begin
      shift_mag = req_ch.shift_bins[SHIFT_W-1] ? SHIFT_W'(-req_ch.shift_bins)
                                               : req_ch.shift_bins;
      mag_ext = MAG_CMP_W'(shift_mag);
      win_ext = MAG_CMP_W'(win);
      shift_n = (mag_ext < win_ext) ? NW'(shift_mag) : win;

      rt_re = {rem_re_ff, dq_re_ff[ACC_W-1]};
      rt_im = {rem_im_ff, dq_im_ff[ACC_W-1]};
      ge_re = rt_re >= {1'b0, divisor_ff};
      ge_im = rt_im >= {1'b0, divisor_ff};
      quo_re = dq_re_ff[SW-1:0];
      quo_im = dq_im_ff[SW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      end_in = end_ff;
      mv_src_in = mv_src_ff;
      mv_dst_in = mv_dst_ff;
      mv_left_in = mv_left_ff;
      mv_down_in = mv_down_ff;
      pend_in = 1'b0;
      pend_dst_in = pend_dst_ff;
      rd_ok_in = rd_ok_ff;
      dq_re_in = dq_re_ff;
      dq_im_in = dq_im_ff;
      rem_re_in = rem_re_ff;
      rem_im_in = rem_im_ff;
      divisor_in = divisor_ff;
      neg_re_in = neg_re_ff;
      neg_im_in = neg_im_ff;
      zero_res_in = zero_res_ff;
      step_in = step_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ch.ready;
      rsp_re_in = rsp_re_ff;
      rsp_im_in = rsp_im_ff;
      rsp_cnt_in = rsp_cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_ch.opcode)
                  OP_CLEAR: begin
                     ptr_in = '0;
                     end_in = NW'(BIN_DEPTH);
                     state_in = ST_SWEEP;
                  end
                  OP_SHIFT: begin
                     mv_left_in = win - shift_n;
                     if (shift_mag == '0) begin
                        state_in = ST_IDLE;
                     end else if (!req_ch.shift_bins[SHIFT_W-1]) begin
                        mv_down_in = 1'b1;
                        mv_src_in = win - NW'(1) - shift_n;
                        mv_dst_in = win - NW'(1);
                        ptr_in = '0;
                        end_in = shift_n;
                        state_in = ST_SHIFT;
                     end else begin
                        mv_down_in = 1'b0;
                        mv_src_in = shift_n;
                        mv_dst_in = '0;
                        ptr_in = win - shift_n;
                        end_in = win;
                        state_in = ST_SHIFT;
                     end
                  end
                  OP_READ: begin
                     rd_ok_in = ridx_calc < BIN_CALC_W'(win);
                     state_in = ST_RD_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP: begin
            if (ptr_ff < end_ff) begin
               ptr_in = ptr_ff + NW'(1);
               if (ptr_in == end_ff) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            if (mv_left_ff != '0) begin
               pend_in = 1'b1;
               pend_dst_in = mv_dst_ff;
               mv_left_in = mv_left_ff - NW'(1);
               if (mv_down_ff) begin
                  mv_src_in = mv_src_ff - NW'(1);
                  mv_dst_in = mv_dst_ff - NW'(1);
               end else begin
                  mv_src_in = mv_src_ff + NW'(1);
                  mv_dst_in = mv_dst_ff + NW'(1);
               end
            end else begin
               state_in = ST_SWEEP;
            end
         end
         ST_RD_LOAD: begin
            divisor_in = rd_ok_ff ? q_cnt : '0;
            zero_res_in = !rd_ok_ff || (q_cnt == '0);
            neg_re_in = q_re[ACC_W-1];
            neg_im_in = q_im[ACC_W-1];
            dq_re_in = q_re[ACC_W-1] ? -q_re : q_re;
            dq_im_in = q_im[ACC_W-1] ? -q_im : q_im;
            rem_re_in = '0;
            rem_im_in = '0;
            step_in = '0;
            state_in = (!rd_ok_ff || (q_cnt == '0)) ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            rem_re_in = ge_re ? CW'(rt_re - {1'b0, divisor_ff}) : rt_re[CW-1:0];
            rem_im_in = ge_im ? CW'(rt_im - {1'b0, divisor_ff}) : rt_im[CW-1:0];
            dq_re_in = {dq_re_ff[ACC_W-2:0], ge_re};
            dq_im_in = {dq_im_ff[ACC_W-2:0], ge_im};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ACC_W - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               rsp_vld_in = 1'b1;
               rsp_cnt_in = divisor_ff;
               if (zero_res_ff) begin
                  rsp_re_in = '0;
                  rsp_im_in = '0;
               end else begin
                  rsp_re_in = neg_re_ff ? -quo_re : quo_re;
                  rsp_im_in = neg_im_ff ? -quo_im : quo_im;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // A new window size zeroes every bin from the new size to the end.
      if (csr_we && csr_index == CSR_WINDOW_BINS) begin
         state_in = ST_SWEEP;
         end_in = NW'(BIN_DEPTH);
         ptr_in = (state_ff == ST_SWEEP && ptr_ff < newwin) ? ptr_ff : newwin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         ptr_ff <= '0;
         end_ff <= NW'(BIN_DEPTH);
         pend_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         fwd_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         end_ff <= end_in;
         pend_ff <= pend_in;
         s1_vld_ff <= s1_vld_in;
         fwd_vld_ff <= we;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mv_src_ff <= mv_src_in;
      mv_dst_ff <= mv_dst_in;
      mv_left_ff <= mv_left_in;
      mv_down_ff <= mv_down_in;
      pend_dst_ff <= pend_dst_in;
      rd_ok_ff <= rd_ok_in;
      dq_re_ff <= dq_re_in;
      dq_im_ff <= dq_im_in;
      rem_re_ff <= rem_re_in;
      rem_im_ff <= rem_im_in;
      divisor_ff <= divisor_in;
      neg_re_ff <= neg_re_in;
      neg_im_ff <= neg_im_in;
      zero_res_ff <= zero_res_in;
      step_ff <= step_in;
      rsp_re_ff <= rsp_re_in;
      rsp_im_ff <= rsp_im_in;
      rsp_cnt_ff <= rsp_cnt_in;
      s1_re_ff <= req_ch.sample_re;
      s1_im_ff <= req_ch.sample_im;
      raddr_ff <= raddr;
      fwd_addr_ff <= waddr;
      fwd_data_ff <= wdata;
   end

   assign rsp_ch.valid = rsp_vld_ff;
   assign rsp_ch.avg_re = rsp_re_ff;
   assign rsp_ch.avg_im = rsp_im_ff;
   assign rsp_ch.bin_count = rsp_cnt_ff;

endmodule

// ----- sv/ssba_checker.sv -----
module ssba_checker #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int COUNT_WIDTH = 16
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [ssba_pkg::OP_W-1:0] req_opcode,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] rsp_avg_re,
   input logic [SAMPLE_WIDTH-1:0] rsp_avg_im,
   input logic [COUNT_WIDTH-1:0] rsp_bin_count
);
   import ssba_pkg::*;

   // No word is taken right after reset, while the clearing pass runs.
   a_reset_clears: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("word accepted during the clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_CLEAR |=> !req_ready)
      else $error("clear did not hold off the next word");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_READ |=> !req_ready)
      else $error("read did not hold off the next word");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bin_count == '0 |-> rsp_avg_re == '0 && rsp_avg_im == '0)
      else $error("empty bin returned a nonzero average");

endmodule

bind swept_spectrum_bin_accumulator_core ssba_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH),
   .COUNT_WIDTH(COUNT_WIDTH)
) u_ssba_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .req_opcode(req_ch.opcode),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_avg_re(rsp_ch.avg_re),
   .rsp_avg_im(rsp_ch.avg_im),
   .rsp_bin_count(rsp_ch.bin_count)
);
